// File: design/quaternion_report_to_euler_codes_assert.svh
// ----------------------------------------------------------------------------
// quaternion report to euler codes assertion macros
// concurrent checks with an asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef QUATERNION_REPORT_TO_EULER_CODES_ASSERT_SVH
`define QUATERNION_REPORT_TO_EULER_CODES_ASSERT_SVH

// same-cycle implication
`define QRE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/qre_pkg.sv
// ----------------------------------------------------------------------------
// qre_pkg
// shared types and constants of the quaternion to euler code pipeline
// ----------------------------------------------------------------------------
package qre_pkg;

	// cordic configuration
	localparam int CORDIC_STEPS  = 16;
	localparam int ANG_TABLE_LEN = 24;
	localparam int ANG_W         = 20;
	localparam int VEC_W         = 34;
	localparam int CW            = 40;
	localparam int NORM_MSB      = 30;

	// pitch front end
	localparam int DIV_STEPS  = 17;
	localparam int SQRT_STEPS = 17;

	// latencies in pipeline stages
	localparam int ATAN_LAT   = 4 + CORDIC_STEPS;
	localparam int PRE_LAT    = DIV_STEPS + 1 + SQRT_STEPS;
	localparam int CODE_LAT   = 4;
	localparam int SIDE_DLY   = PRE_LAT + ATAN_LAT + CODE_LAT;
	localparam int PIPE_DEPTH = 3 + SIDE_DLY;
	localparam int NUM_ANG    = 3;

	// angles in radians with 16 fractional bits
	localparam logic signed [ANG_W-1:0] HALF_PI = 20'sd102944;
	localparam logic signed [ANG_W-1:0] ATAN_TABLE [ANG_TABLE_LEN] = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
		20'sd16, 20'sd8, 20'sd4, 20'sd2, 20'sd1, 20'sd0,
		20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0
	};

	// angle code: (a * rad2deg + 200 * 2^32) / (25 * 2^20)
	localparam logic signed [22:0] RAD2DEG     = 23'sd3754936;
	localparam logic signed [43:0] CODE_OFFSET = 44'sd858993459200;
	localparam int                 CODE_SHIFT  = 20;
	localparam logic [20:0]        CODE_SAT_X  = 21'd1638400;
	localparam logic [21:0]        RECIP_25    = 22'd2684355;
	localparam int                 RECIP_SHIFT = 26;

	// accuracy code: acc * 4 / 25
	localparam logic [17:0] ACC_RECIP    = 18'd167773;
	localparam int          ACC_SHIFT    = 22;
	localparam logic [15:0] ACC_CODE_MAX = 16'd5242;

	localparam logic [7:0] REPORT_ID_RESET = 8'h28;

	typedef struct packed {
		logic        [7:0]  report_id;
		logic signed [15:0] quat_i_raw;
		logic signed [15:0] quat_j_raw;
		logic signed [15:0] quat_k_raw;
		logic signed [15:0] quat_real_raw;
		logic signed [15:0] accuracy_raw;
	} report_t;

	typedef struct packed {
		logic        valid_res;
		logic [15:0] roll_code;
		logic [15:0] pitch_code;
		logic [15:0] yaw_code;
		logic [15:0] accuracy_code;
	} codes_t;

endpackage

// File: design/qre_if.sv
// ----------------------------------------------------------------------------
// qre channel interfaces
// valid/ready channels for reports, result codes and the id register
// ----------------------------------------------------------------------------
interface qre_report_if;
	logic             valid;
	logic             ready;
	qre_pkg::report_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qre_codes_if;
	logic            valid;
	logic            ready;
	qre_pkg::codes_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qre_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/qre_atan2.sv
// ----------------------------------------------------------------------------
// qre_atan2
// pipelined vectoring cordic atan2, one cordic step per stage
// ----------------------------------------------------------------------------
module qre_atan2 (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [qre_pkg::VEC_W-1:0]   x,
	input  logic signed [qre_pkg::VEC_W-1:0]   y,
	output logic signed [qre_pkg::ANG_W-1:0]   z
);

	logic signed [qre_pkg::VEC_W-1:0] x_s1, y_s1, x_s2, y_s2;
	logic        [qre_pkg::VEC_W-1:0] mag_s1;
	logic                             zero_s1, zero_s2, zero_s3;
	logic        [4:0]                sh_s2;
	logic signed [qre_pkg::CW-1:0]    x_s3, y_s3;

	logic        [qre_pkg::VEC_W-1:0] ax, ay;
	logic        [5:0]                msb;
	logic        [4:0]                sh;
	logic signed [qre_pkg::CW-1:0]    px, py;
	logic signed [qre_pkg::ANG_W-1:0] pz;

	logic signed [qre_pkg::CW-1:0]    cx_s [qre_pkg::CORDIC_STEPS+1];
	logic signed [qre_pkg::CW-1:0]    cy_s [qre_pkg::CORDIC_STEPS+1];
	logic signed [qre_pkg::ANG_W-1:0] cz_s [qre_pkg::CORDIC_STEPS+1];
	logic                             zr_s [qre_pkg::CORDIC_STEPS+1];

	// magnitudes, or-ed to find the leading one
	assign ax = x[qre_pkg::VEC_W-1] ? (~x + 1'b1) : x;
	assign ay = y[qre_pkg::VEC_W-1] ? (~y + 1'b1) : y;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x;
			y_s1    <= y;
			mag_s1  <= ax | ay;
			zero_s1 <= (x == '0) && (y == '0);
		end
	end

	// leading one search and doubling count
	always_comb begin
		msb = '0;
		for (int i = 0; i < qre_pkg::VEC_W; i++) begin
			if (mag_s1[i]) msb = 6'(i);
		end
		sh = (msb >= 6'(qre_pkg::NORM_MSB)) ? 5'd0 : 5'(6'(qre_pkg::NORM_MSB) - msb);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			sh_s2   <= sh;
			zero_s2 <= zero_s1;
		end
	end

	// normalizing shift
	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= {{(qre_pkg::CW-qre_pkg::VEC_W){x_s2[qre_pkg::VEC_W-1]}}, x_s2} <<< sh_s2;
			y_s3    <= {{(qre_pkg::CW-qre_pkg::VEC_W){y_s2[qre_pkg::VEC_W-1]}}, y_s2} <<< sh_s2;
			zero_s3 <= zero_s2;
		end
	end

	// quarter turn into the right half plane
	always_comb begin
		px = x_s3;
		py = y_s3;
		pz = '0;
		if (x_s3[qre_pkg::CW-1]) begin
			if (!y_s3[qre_pkg::CW-1]) begin
				px = y_s3;
				py = -x_s3;
				pz = qre_pkg::HALF_PI;
			end else begin
				px = -y_s3;
				py = x_s3;
				pz = -qre_pkg::HALF_PI;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= px;
			cy_s[0] <= py;
			cz_s[0] <= pz;
			zr_s[0] <= zero_s3;
		end
	end

	// cordic steps, rotate toward y = 0
	for (genvar i = 0; i < qre_pkg::CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[i][qre_pkg::CW-1]) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + qre_pkg::ATAN_TABLE[i];
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - qre_pkg::ATAN_TABLE[i];
				end
				zr_s[i+1] <= zr_s[i];
			end
		end
	end

	// zero vector gives angle zero
	assign z = zr_s[qre_pkg::CORDIC_STEPS] ? '0 : cz_s[qre_pkg::CORDIC_STEPS];

endmodule

// File: design/quaternion_report_to_euler_codes.sv
// ----------------------------------------------------------------------------
// quaternion_report_to_euler_codes
// rotation vector report to roll, pitch, yaw and accuracy codes
// ----------------------------------------------------------------------------
// path: an accepted report passes 3 front stages, 35 pitch divide/sqrt stages,
//   20 cordic and 4 code stages on its way into the output register
// throughput: one report per cycle while the skid register is empty; every
//   stage advances together, and a skid register lets the pipeline run on while one result waits
// reset: clears all valid bits, including the output and skid valid flags; id register 0x28
// ----------------------------------------------------------------------------
`include "quaternion_report_to_euler_codes_assert.svh"

module quaternion_report_to_euler_codes (
	input  logic        clk,
	input  logic        arst_n,
	qre_cfg_if.sink     cfg,
	qre_report_if.sink  report,
	qre_codes_if.source codes
);

	logic [7:0] exp_id_q;
	logic       en;
	logic       push, take;
	logic       out_v_q, skid_v_q;
	qre_pkg::codes_t out_d_q, skid_d_q, pd;

	logic [qre_pkg::PIPE_DEPTH-1:0] valid_s;

	// stage 1
	logic               match_s1;
	logic signed [15:0] qi_s1, qj_s1, qk_s1, qr_s1, acc_s1;
	// stage 2
	logic signed [31:0] p_ii_s2, p_jj_s2, p_kk_s2, p_rr_s2;
	logic signed [31:0] p_jk_s2, p_ir_s2, p_ij_s2, p_kr_s2, p_ik_s2, p_jr_s2;
	logic        [34:0] acc_prod_s2;
	logic               acc_pos_s2, match_s2;
	// stage 3
	logic signed [qre_pkg::VEC_W-1:0] roll_x_s3, roll_y_s3, yaw_x_s3, yaw_y_s3;
	logic        [32:0] n_s3, t_mag_s3;
	logic               t_neg_s3, match_s3;
	logic        [12:0] acc_code_s3;
	logic signed [qre_pkg::VEC_W-1:0] t_full;

	// pitch divider
	logic [32:0] dv_rem_sd [qre_pkg::DIV_STEPS];
	logic [32:0] dv_den_sd [qre_pkg::DIV_STEPS];
	logic [16:0] dv_quo_sd [qre_pkg::DIV_STEPS];
	logic        dv_neg_sd [qre_pkg::DIV_STEPS];
	logic        dv_nz_sd  [qre_pkg::DIV_STEPS];

	// sine and square
	logic signed [17:0] pit_s_sx;
	logic        [32:0] pit_v_sx;
	logic        [16:0] qs;
	logic        [33:0] qq;

	// square root
	logic        [32:0] sr_v_sr   [qre_pkg::SQRT_STEPS];
	logic        [33:0] sr_res_sr [qre_pkg::SQRT_STEPS];
	logic signed [17:0] sr_s_sr   [qre_pkg::SQRT_STEPS];

	// atan2 results
	logic signed [qre_pkg::ANG_W-1:0] roll_z, pitch_z, yaw_z;
	logic signed [qre_pkg::VEC_W-1:0] pit_x, pit_y;

	// alignment delays
	logic signed [qre_pkg::ANG_W-1:0] rl_dly_sk    [qre_pkg::PRE_LAT];
	logic signed [qre_pkg::ANG_W-1:0] yw_dly_sk    [qre_pkg::PRE_LAT];
	logic        [12:0]               acc_dly_sk   [qre_pkg::SIDE_DLY];
	logic                             match_dly_sk [qre_pkg::SIDE_DLY];

	// code lanes: roll, pitch, yaw
	logic signed [qre_pkg::ANG_W-1:0] ang        [qre_pkg::NUM_ANG];
	logic signed [43:0]               cd_num_sc1 [qre_pkg::NUM_ANG];
	logic        [20:0]               cd_xs      [qre_pkg::NUM_ANG];
	logic                             cd_pos     [qre_pkg::NUM_ANG];
	logic        [20:0]               cd_x_sc2   [qre_pkg::NUM_ANG];
	logic                             cd_sat_sc2 [qre_pkg::NUM_ANG];
	logic        [42:0]               cd_prd_sc3 [qre_pkg::NUM_ANG];
	logic                             cd_sat_sc3 [qre_pkg::NUM_ANG];
	logic        [15:0]               cd_code_sc4 [qre_pkg::NUM_ANG];

	// id register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q <= qre_pkg::REPORT_ID_RESET;
		end else if (cfg.valid) begin
			exp_id_q <= cfg.data;
		end
	end

	// whole pipeline advances unless the skid register is full
	assign en           = !skid_v_q;
	assign report.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[qre_pkg::PIPE_DEPTH-2:0], report.valid};
		end
	end

	// stage 1: capture report
	always_ff @(posedge clk) begin
		if (en) begin
			match_s1 <= (report.data.report_id == exp_id_q);
			qi_s1    <= report.data.quat_i_raw;
			qj_s1    <= report.data.quat_j_raw;
			qk_s1    <= report.data.quat_k_raw;
			qr_s1    <= report.data.quat_real_raw;
			acc_s1   <= report.data.accuracy_raw;
		end
	end

	// stage 2: quaternion products and accuracy scaling
	always_ff @(posedge clk) begin
		if (en) begin
			p_ii_s2     <= qi_s1 * qi_s1;
			p_jj_s2     <= qj_s1 * qj_s1;
			p_kk_s2     <= qk_s1 * qk_s1;
			p_rr_s2     <= qr_s1 * qr_s1;
			p_jk_s2     <= qj_s1 * qk_s1;
			p_ir_s2     <= qi_s1 * qr_s1;
			p_ij_s2     <= qi_s1 * qj_s1;
			p_kr_s2     <= qk_s1 * qr_s1;
			p_ik_s2     <= qi_s1 * qk_s1;
			p_jr_s2     <= qj_s1 * qr_s1;
			acc_prod_s2 <= 35'({acc_s1[14:0], 2'b00}) * 35'(qre_pkg::ACC_RECIP);
			acc_pos_s2  <= !acc_s1[15] && (acc_s1 != '0);
			match_s2    <= match_s1;
		end
	end

	// stage 3: atan2 operands, pitch numerator and norm
	assign t_full = (34'(p_jr_s2) - 34'(p_ik_s2)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			roll_y_s3   <= (34'(p_jk_s2) + 34'(p_ir_s2)) <<< 1;
			roll_x_s3   <= 34'(p_kk_s2) + 34'(p_rr_s2) - 34'(p_ii_s2) - 34'(p_jj_s2);
			yaw_y_s3    <= (34'(p_ij_s2) + 34'(p_kr_s2)) <<< 1;
			yaw_x_s3    <= 34'(p_ii_s2) + 34'(p_rr_s2) - 34'(p_jj_s2) - 34'(p_kk_s2);
			n_s3        <= 33'(34'(p_ii_s2) + 34'(p_jj_s2) + 34'(p_kk_s2) + 34'(p_rr_s2));
			t_neg_s3    <= t_full[qre_pkg::VEC_W-1];
			t_mag_s3    <= 33'(t_full[qre_pkg::VEC_W-1] ? (~t_full + 1'b1) : t_full);
			acc_code_s3 <= acc_pos_s2 ? acc_prod_s2[qre_pkg::ACC_SHIFT +: 13] : 13'd0;
			match_s3    <= match_s2;
		end
	end

	// restoring divider, one quotient bit per stage; |t| <= n keeps it in 17 bits
	for (genvar j = 0; j < qre_pkg::DIV_STEPS; j++) begin : g_div
		logic [33:0] cur;
		logic [32:0] den;
		logic [16:0] qin;
		logic        neg, nz, ge;

		if (j == 0) begin : g_first
			assign cur = {1'b0, t_mag_s3};
			assign den = n_s3;
			assign qin = '0;
			assign neg = t_neg_s3;
			assign nz  = (n_s3 != '0);
		end else begin : g_next
			assign cur = {dv_rem_sd[j-1], 1'b0};
			assign den = dv_den_sd[j-1];
			assign qin = dv_quo_sd[j-1];
			assign neg = dv_neg_sd[j-1];
			assign nz  = dv_nz_sd[j-1];
		end

		assign ge = (cur >= {1'b0, den});

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_sd[j] <= 33'(ge ? (cur - {1'b0, den}) : cur);
				dv_den_sd[j] <= den;
				dv_quo_sd[j] <= {qin[15:0], ge};
				dv_neg_sd[j] <= neg;
				dv_nz_sd[j]  <= nz;
			end
		end
	end

	// signed sine and radicand 2^32 - s^2; zero norm gives sine zero
	assign qs = dv_nz_sd[qre_pkg::DIV_STEPS-1] ? dv_quo_sd[qre_pkg::DIV_STEPS-1] : 17'd0;
	assign qq = 34'(qs) * 34'(qs);

	always_ff @(posedge clk) begin
		if (en) begin
			pit_s_sx <= dv_neg_sd[qre_pkg::DIV_STEPS-1] ? -$signed({1'b0, qs})
			                                              : $signed({1'b0, qs});
			pit_v_sx <= 33'(34'd4294967296 - qq);
		end
	end

	// bit-by-bit square root, one result bit per stage
	for (genvar i = 0; i < qre_pkg::SQRT_STEPS; i++) begin : g_sqrt
		localparam logic [33:0] BITV = 34'd1 << (32 - 2 * i);
		logic        [32:0] vin;
		logic        [33:0] rin, trial;
		logic signed [17:0] sin;
		logic               ge;

		if (i == 0) begin : g_first
			assign vin = pit_v_sx;
			assign rin = '0;
			assign sin = pit_s_sx;
		end else begin : g_next
			assign vin = sr_v_sr[i-1];
			assign rin = sr_res_sr[i-1];
			assign sin = sr_s_sr[i-1];
		end

		assign trial = rin + BITV;
		assign ge    = ({1'b0, vin} >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sr_v_sr[i]   <= ge ? 33'({1'b0, vin} - trial) : vin;
				sr_res_sr[i] <= ge ? ((rin >> 1) + BITV) : (rin >> 1);
				sr_s_sr[i]   <= sin;
			end
		end
	end

	assign pit_x = $signed(34'({1'b0, sr_res_sr[qre_pkg::SQRT_STEPS-1][16:0]}));
	assign pit_y = 34'(sr_s_sr[qre_pkg::SQRT_STEPS-1]);

	// atan2 units
	qre_atan2 u_roll (.clk(clk), .en(en), .x(roll_x_s3), .y(roll_y_s3), .z(roll_z));
	qre_atan2 u_yaw  (.clk(clk), .en(en), .x(yaw_x_s3),  .y(yaw_y_s3),  .z(yaw_z));
	qre_atan2 u_pitch(.clk(clk), .en(en), .x(pit_x),     .y(pit_y),     .z(pitch_z));

	// roll and yaw wait for the pitch front end
	always_ff @(posedge clk) begin
		if (en) begin
			rl_dly_sk[0] <= roll_z;
			yw_dly_sk[0] <= yaw_z;
			for (int k = 1; k < qre_pkg::PRE_LAT; k++) begin
				rl_dly_sk[k] <= rl_dly_sk[k-1];
				yw_dly_sk[k] <= yw_dly_sk[k-1];
			end
		end
	end

	// accuracy code and id match ride along
	always_ff @(posedge clk) begin
		if (en) begin
			acc_dly_sk[0]   <= acc_code_s3;
			match_dly_sk[0] <= match_s3;
			for (int k = 1; k < qre_pkg::SIDE_DLY; k++) begin
				acc_dly_sk[k]   <= acc_dly_sk[k-1];
				match_dly_sk[k] <= match_dly_sk[k-1];
			end
		end
	end

	// angle code lanes
	assign ang[0] = rl_dly_sk[qre_pkg::PRE_LAT-1];
	assign ang[1] = pitch_z;
	assign ang[2] = yw_dly_sk[qre_pkg::PRE_LAT-1];

	always_comb begin
		for (int l = 0; l < qre_pkg::NUM_ANG; l++) begin
			cd_xs[l]  = 21'(cd_num_sc1[l] >>> qre_pkg::CODE_SHIFT);
			cd_pos[l] = !cd_num_sc1[l][43] && (cd_num_sc1[l] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < qre_pkg::NUM_ANG; l++) begin
				cd_num_sc1[l]  <= 44'(ang[l]) * 44'(qre_pkg::RAD2DEG) + qre_pkg::CODE_OFFSET;
				cd_x_sc2[l]    <= cd_pos[l] ? cd_xs[l] : 21'd0;
				cd_sat_sc2[l]  <= cd_pos[l] && (cd_xs[l] >= qre_pkg::CODE_SAT_X);
				cd_prd_sc3[l]  <= 43'(cd_x_sc2[l]) * 43'(qre_pkg::RECIP_25);
				cd_sat_sc3[l]  <= cd_sat_sc2[l];
				cd_code_sc4[l] <= cd_sat_sc3[l] ? 16'hFFFF
				                                : cd_prd_sc3[l][qre_pkg::RECIP_SHIFT +: 16];
			end
		end
	end

	// final result, zero codes on id mismatch
	always_comb begin
		pd.valid_res     = match_dly_sk[qre_pkg::SIDE_DLY-1];
		pd.roll_code     = pd.valid_res ? cd_code_sc4[0] : 16'd0;
		pd.pitch_code    = pd.valid_res ? cd_code_sc4[1] : 16'd0;
		pd.yaw_code      = pd.valid_res ? cd_code_sc4[2] : 16'd0;
		pd.accuracy_code = pd.valid_res ? {3'b000, acc_dly_sk[qre_pkg::SIDE_DLY-1]} : 16'd0;
	end

	// output register with skid
	assign push = valid_s[qre_pkg::PIPE_DEPTH-1] && en;
	assign take = out_v_q && codes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (out_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_v_q) begin
				out_d_q <= skid_d_q;
			end else if (push) begin
				out_d_q <= pd;
			end
		end else if (push) begin
			if (out_v_q) begin
				skid_d_q <= pd;
			end else begin
				out_d_q <= pd;
			end
		end
	end

	assign codes.valid = out_v_q;
	assign codes.data  = out_d_q;

	// checks
	`QRE_ASSERT_IMPL(a_skid_has_out, clk, arst_n, skid_v_q, out_v_q,
		"skid holds a transaction while the output register is empty")
	`QRE_ASSERT_NEXT(a_skid_fill, clk, arst_n,
		push && out_v_q && !codes.ready, skid_v_q,
		"transaction leaving the pipeline was dropped")
	`QRE_ASSERT_IMPL(a_mismatch_zero, clk, arst_n,
		codes.valid && !codes.data.valid_res,
		codes.data.roll_code == 16'd0 && codes.data.pitch_code == 16'd0 &&
		codes.data.yaw_code == 16'd0 && codes.data.accuracy_code == 16'd0,
		"mismatched report carries nonzero codes")
	`QRE_ASSERT_IMPL(a_acc_range, clk, arst_n, codes.valid,
		codes.data.accuracy_code <= qre_pkg::ACC_CODE_MAX,
		"accuracy code beyond its reachable range")

endmodule
